/* rtl/websocket_masked_frame_builder_unit_assert.svh */
// Assertion macros used by the checker of the masked frame builder.
`ifndef WEBSOCKET_MASKED_FRAME_BUILDER_UNIT_ASSERT_SVH
`define WEBSOCKET_MASKED_FRAME_BUILDER_UNIT_ASSERT_SVH

// Same-cycle implication, ignored while reset is asserted.
`define WSMFB_ASSERT_IMPL(label, clk, rst_n, ante, cons, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error(msg);

// Next-cycle implication, ignored while reset is asserted.
`define WSMFB_ASSERT_NEXT(label, clk, rst_n, ante, cons, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error(msg);

// Next-cycle implication that is checked through reset as well.
`define WSMFB_ASSERT_ALWAYS_NEXT(label, clk, ante, cons, msg) \
    label: assert property (@(posedge clk) (ante) |=> (cons)) \
        else $error(msg);

`endif

/* rtl/wsmfb_pkg.sv */
// ----------------------------------------------------------------------------
// wsmfb_pkg
// Types and constants shared by the masked WebSocket frame builder.
// ----------------------------------------------------------------------------
package wsmfb_pkg;

    // Width of the length field that is actually carried in the header.
    localparam int LENGTH_BITS = 32;
    localparam logic [63:0] LEN_MASK = (LENGTH_BITS >= 64) ? {64{1'b1}} :
                                       ((64'd1 << LENGTH_BITS) - 64'd1);

    // Input word layout, lowest bit first.
    localparam int OPCODE_W  = 4;
    localparam int LENGTH_W  = 32;
    localparam int KEY_W     = 32;
    localparam int BYTE_W    = 8;
    localparam int OPCODE_LO = 0;
    localparam int LENGTH_LO = OPCODE_LO + OPCODE_W;
    localparam int KEY_LO    = LENGTH_LO + LENGTH_W;
    localparam int DATA_LO   = KEY_LO + KEY_W;
    localparam int IN_BITS   = DATA_LO + BYTE_W;
    localparam int IN_TDATA_W = ((IN_BITS + 7) / 8) * 8;

    // Header run: FIN byte, length byte, up to eight length bytes, four key bytes.
    localparam int HDR_BYTES = 14;
    localparam int HDR_W     = HDR_BYTES * 8;
    localparam int CNT_W     = $clog2(HDR_BYTES);

    localparam logic [7:0]  FIN_BIT     = 8'h80;
    localparam logic [7:0]  MASKED_FLAG = 8'h80;
    localparam logic [6:0]  LEN16_CODE  = 7'd126;
    localparam logic [6:0]  LEN64_CODE  = 7'd127;
    localparam logic [63:0] LEN16_MAX   = 64'd65535;

    localparam logic REQ_START   = 1'b0;
    localparam logic REQ_PAYLOAD = 1'b1;

    // Commands from the controller to the datapath.
    typedef struct packed {
        logic ld_start;   // capture the header run and the key
        logic ld_payload; // load a masked payload byte into the output register
        logic ld_hdr;     // move the next header byte into the output register
    } t_cmd;

    // Status from the datapath to the controller.
    typedef struct packed {
        logic hdr_last;   // the next header byte is the final one of the run
    } t_status;

endpackage

/* rtl/websocket_masked_frame_builder_unit.sv */
// ----------------------------------------------------------------------------
// websocket_masked_frame_builder_unit
// Builds a masked client-to-server WebSocket frame as a byte stream.
// ----------------------------------------------------------------------------
// Input stream: s_axis_tuser selects the request kind (0 starts a frame,
// 1 carries one payload byte); s_axis_tdata holds opcode, length, key and
// data byte. Output stream: one frame byte per transfer, m_axis_tuser marks
// header and key bytes, m_axis_tlast marks the final byte a request causes.
// A payload request is masked with the stored key and appears on the output
// in the cycle after acceptance; payload requests sustain one per cycle while
// the receiver takes every byte. A start request loads the header shift
// register, which emits one byte per cycle while the receiver takes them;
// no request is taken until its last byte has moved into the output register,
// after which the next one can be taken in the same cycle the tail byte waits.
// Reset clears the stored key and the mask position to zero and empties the
// output register. When the receiver stalls the output register holds its
// byte, and s_axis_tready falls until the byte is taken.
// ----------------------------------------------------------------------------
module websocket_masked_frame_builder_unit (
    input  logic                                 i_clk,
    input  logic                                 i_rst_n,
    input  logic                                 s_axis_tvalid,
    output logic                                 s_axis_tready,
    // Fields from bit 0: opcode[3:0], frame_len[35:4], mask_key[67:36],
    // data_byte[75:68], zero padding[79:76].
    input  logic [wsmfb_pkg::IN_TDATA_W-1:0]     s_axis_tdata,
    // Fields from bit 0: req_type.
    input  logic                                 s_axis_tuser,
    output logic                                 m_axis_tvalid,
    input  logic                                 m_axis_tready,
    // Fields from bit 0: out_byte[7:0].
    output logic [wsmfb_pkg::BYTE_W-1:0]         m_axis_tdata,
    // Fields from bit 0: is_header.
    output logic                                 m_axis_tuser,
    output logic                                 m_axis_tlast
);

    wsmfb_pkg::t_cmd    cmd;
    wsmfb_pkg::t_status status;

    wsmfb_ctrl u_ctrl (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_in_valid  (s_axis_tvalid),
        .i_in_kind   (s_axis_tuser),
        .o_in_ready  (s_axis_tready),
        .i_out_ready (m_axis_tready),
        .o_out_valid (m_axis_tvalid),
        .i_status    (status),
        .o_cmd       (cmd)
    );

    wsmfb_datapath u_datapath (
        .i_clk            (i_clk),
        .i_rst_n          (i_rst_n),
        .i_opcode         (s_axis_tdata[wsmfb_pkg::OPCODE_LO +: wsmfb_pkg::OPCODE_W]),
        .i_frame_len      (s_axis_tdata[wsmfb_pkg::LENGTH_LO +: wsmfb_pkg::LENGTH_W]),
        .i_mask_key       (s_axis_tdata[wsmfb_pkg::KEY_LO +: wsmfb_pkg::KEY_W]),
        .i_data_byte      (s_axis_tdata[wsmfb_pkg::DATA_LO +: wsmfb_pkg::BYTE_W]),
        .i_cmd            (cmd),
        .o_status         (status),
        .o_out_byte       (m_axis_tdata),
        .o_is_header      (m_axis_tuser),
        .o_last_of_run    (m_axis_tlast)
    );

endmodule

/* rtl/wsmfb_ctrl.sv */
// ----------------------------------------------------------------------------
// wsmfb_ctrl
// Handshake controller: accepts requests, sequences the header run and owns
// the output valid flag.
// ----------------------------------------------------------------------------
module wsmfb_ctrl (
    input  logic               i_clk,
    input  logic               i_rst_n,
    input  logic               i_in_valid,
    input  logic               i_in_kind,
    output logic               o_in_ready,
    input  logic               i_out_ready,
    output logic               o_out_valid,
    input  wsmfb_pkg::t_status i_status,
    output wsmfb_pkg::t_cmd    o_cmd
);

    typedef enum logic [1:0] {
        S_RUN = 2'b01,
        S_HDR = 2'b10
    } t_state;

    t_state r_state, n_state;
    logic   r_out_valid, n_out_valid;
    logic   out_free;
    logic   accept;

    assign out_free    = !r_out_valid || i_out_ready;
    assign o_out_valid = r_out_valid;

    always_comb begin
        n_state     = r_state;
        n_out_valid = r_out_valid && !i_out_ready;
        o_cmd       = '0;
        o_in_ready  = 1'b0;
        accept      = 1'b0;
        unique case (r_state)
            S_RUN: begin
                o_in_ready = out_free;
                accept     = i_in_valid && out_free;
                if (accept) begin
                    if (i_in_kind == wsmfb_pkg::REQ_PAYLOAD) begin
                        o_cmd.ld_payload = 1'b1;
                        n_out_valid      = 1'b1;
                    end else begin
                        o_cmd.ld_start = 1'b1;
                        n_state        = S_HDR;
                    end
                end
            end
            S_HDR: begin
                if (out_free) begin
                    o_cmd.ld_hdr = 1'b1;
                    n_out_valid  = 1'b1;
                    if (i_status.hdr_last) begin
                        n_state = S_RUN;
                    end
                end
            end
            default: begin
                n_state     = S_RUN;
                n_out_valid = 1'b0;
            end
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state     <= S_RUN;
            r_out_valid <= 1'b0;
        end else begin
            r_state     <= n_state;
            r_out_valid <= n_out_valid;
        end
    end

endmodule

/* rtl/wsmfb_datapath.sv */
// ----------------------------------------------------------------------------
// wsmfb_datapath
// Header builder, header shift register, mask key store and output register.
// ----------------------------------------------------------------------------
module wsmfb_datapath (
    input  logic                                i_clk,
    input  logic                                i_rst_n,
    input  logic [wsmfb_pkg::OPCODE_W-1:0]      i_opcode,
    input  logic [wsmfb_pkg::LENGTH_W-1:0]      i_frame_len,
    input  logic [wsmfb_pkg::KEY_W-1:0]         i_mask_key,
    input  logic [wsmfb_pkg::BYTE_W-1:0]        i_data_byte,
    input  wsmfb_pkg::t_cmd                     i_cmd,
    output wsmfb_pkg::t_status                  o_status,
    output logic [wsmfb_pkg::BYTE_W-1:0]        o_out_byte,
    output logic                                o_is_header,
    output logic                                o_last_of_run
);

    logic [wsmfb_pkg::HDR_W-1:0] r_hdr, n_hdr_load;
    logic [wsmfb_pkg::CNT_W-1:0] r_cnt, n_cnt_load;
    logic [wsmfb_pkg::KEY_W-1:0] r_key;
    logic [1:0]                  r_pos;
    logic [7:0]                  r_out_byte;
    logic                        r_is_header;
    logic                        r_last;
    logic [63:0]                 len64;
    logic [7:0]                  hb [wsmfb_pkg::HDR_BYTES];
    logic [7:0]                  mask_byte;

    assign len64 = 64'(i_frame_len) & wsmfb_pkg::LEN_MASK;

    // Lay out the header run, first byte at index zero.
    always_comb begin
        for (int i = 0; i < wsmfb_pkg::HDR_BYTES; i++) begin
            hb[i] = 8'h00;
        end
        hb[0] = wsmfb_pkg::FIN_BIT | 8'(i_opcode);
        if (len64 < 64'(wsmfb_pkg::LEN16_CODE)) begin
            hb[1] = wsmfb_pkg::MASKED_FLAG | {1'b0, len64[6:0]};
            for (int i = 0; i < 4; i++) begin
                hb[2 + i] = i_mask_key[8 * (3 - i) +: 8];
            end
            n_cnt_load = wsmfb_pkg::CNT_W'(5);
        end else if (len64 <= wsmfb_pkg::LEN16_MAX) begin
            hb[1] = wsmfb_pkg::MASKED_FLAG | {1'b0, wsmfb_pkg::LEN16_CODE};
            hb[2] = len64[15:8];
            hb[3] = len64[7:0];
            for (int i = 0; i < 4; i++) begin
                hb[4 + i] = i_mask_key[8 * (3 - i) +: 8];
            end
            n_cnt_load = wsmfb_pkg::CNT_W'(7);
        end else begin
            hb[1] = wsmfb_pkg::MASKED_FLAG | {1'b0, wsmfb_pkg::LEN64_CODE};
            for (int i = 0; i < 8; i++) begin
                hb[2 + i] = len64[8 * (7 - i) +: 8];
            end
            // The top bit of the 64-bit length is always sent as zero.
            hb[2][7] = 1'b0;
            for (int i = 0; i < 4; i++) begin
                hb[10 + i] = i_mask_key[8 * (3 - i) +: 8];
            end
            n_cnt_load = wsmfb_pkg::CNT_W'(13);
        end
        for (int i = 0; i < wsmfb_pkg::HDR_BYTES; i++) begin
            n_hdr_load[8 * (wsmfb_pkg::HDR_BYTES - 1 - i) +: 8] = hb[i];
        end
    end

    // Position p selects key bits 31-8p down to 24-8p.
    assign mask_byte = r_key[{~r_pos, 3'b000} +: 8];

    assign o_status.hdr_last = (r_cnt == '0);

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_key <= '0;
            r_pos <= '0;
            r_cnt <= '0;
        end else if (i_cmd.ld_start) begin
            r_key <= i_mask_key;
            r_pos <= '0;
            r_cnt <= n_cnt_load;
        end else if (i_cmd.ld_payload) begin
            r_pos <= r_pos + 2'd1;
        end else if (i_cmd.ld_hdr) begin
            r_cnt <= r_cnt - wsmfb_pkg::CNT_W'(1);
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_cmd.ld_start) begin
            r_hdr <= n_hdr_load;
        end else if (i_cmd.ld_hdr) begin
            r_hdr <= {r_hdr[wsmfb_pkg::HDR_W-9:0], 8'h00};
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_cmd.ld_payload) begin
            r_out_byte  <= i_data_byte ^ mask_byte;
            r_is_header <= 1'b0;
            r_last      <= 1'b1;
        end else if (i_cmd.ld_hdr) begin
            r_out_byte  <= r_hdr[wsmfb_pkg::HDR_W-1 -: 8];
            r_is_header <= 1'b1;
            r_last      <= (r_cnt == '0);
        end
    end

    assign o_out_byte    = r_out_byte;
    assign o_is_header   = r_is_header;
    assign o_last_of_run = r_last;

endmodule

/* rtl/wsmfb_checker.sv */
// ----------------------------------------------------------------------------
// wsmfb_checker
// Port-level checks on the masked frame builder, bound to the top level.
// ----------------------------------------------------------------------------
`include "websocket_masked_frame_builder_unit_assert.svh"

module wsmfb_checker (
    input logic                             i_clk,
    input logic                             i_rst_n,
    input logic                             s_axis_tready,
    input logic                             m_axis_tvalid,
    input logic                             m_axis_tready,
    input logic [wsmfb_pkg::BYTE_W-1:0]     m_axis_tdata,
    input logic                             m_axis_tuser,
    input logic                             m_axis_tlast
);

    // The output register is empty straight after reset.
    `WSMFB_ASSERT_ALWAYS_NEXT(a_reset_empty, i_clk, !i_rst_n, !m_axis_tvalid,
        "output valid after reset")

    // A stalled output request keeps its contents.
    `WSMFB_ASSERT_NEXT(a_stall_hold, i_clk, i_rst_n, m_axis_tvalid && !m_axis_tready,
        m_axis_tvalid && $stable(m_axis_tdata) && $stable(m_axis_tuser)
        && $stable(m_axis_tlast), "stalled output changed")

    // A payload byte is always the only result of its request.
    `WSMFB_ASSERT_IMPL(a_payload_last, i_clk, i_rst_n, m_axis_tvalid && !m_axis_tuser,
        m_axis_tlast, "payload byte without tlast")

    // No new request is taken while a header run is still being sent.
    `WSMFB_ASSERT_IMPL(a_hdr_blocks, i_clk, i_rst_n,
        m_axis_tvalid && m_axis_tuser && !m_axis_tlast, !s_axis_tready,
        "request taken during header run")

endmodule

bind websocket_masked_frame_builder_unit wsmfb_checker u_wsmfb_checker (
    .i_clk         (i_clk),
    .i_rst_n       (i_rst_n),
    .s_axis_tready (s_axis_tready),
    .m_axis_tvalid (m_axis_tvalid),
    .m_axis_tready (m_axis_tready),
    .m_axis_tdata  (m_axis_tdata),
    .m_axis_tuser  (m_axis_tuser),
    .m_axis_tlast  (m_axis_tlast)
);
